// ===== hw/rtl/hfd_pkg.sv =====
// hfd_pkg: shared types and constants for the host frame deframer
// item structs, event codes and payload store geometry
// no dependencies
package hfd_pkg;

	// payload store geometry
	localparam int STORE_DEPTH = 256;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	// framing constants
	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] HDR_BYTE  = 8'h55;
	localparam logic [7:0] XOR_MARK  = 8'h81;

	// request and event codes
	localparam logic REQ_RX   = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic [1:0] EV_CONSUMED = 2'd0;
	localparam logic [1:0] EV_ACCEPTED = 2'd1;
	localparam logic [1:0] EV_MISMATCH = 2'd2;
	localparam logic [1:0] EV_READ     = 2'd3;

	// input item
	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [1:0] event_res;
		logic [7:0] frame_length;
		logic [7:0] read_data;
	} rsp_t;

	// store write port
	typedef struct packed {
		logic                en;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          data;
	} store_wr_t;

	// store read port
	typedef struct packed {
		logic                en;
		logic [STORE_AW-1:0] addr;
	} store_rd_t;

endpackage

// ===== hw/rtl/hfd_store.sv =====
// hfd_store: payload byte memory, one write and one registered read per cycle
// depends on hfd_pkg
module hfd_store (
	input  logic                clk,
	input  hfd_pkg::store_wr_t  wr,
	input  hfd_pkg::store_rd_t  rd,
	output logic [7:0]          rd_data_q
);

	logic [7:0] mem [hfd_pkg::STORE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

endmodule

// ===== hw/rtl/host_frame_deframer.sv =====
// host_frame_deframer: frame hunt, checksum, payload store with xor fixup
// depends on hfd_pkg and hfd_store
//
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid, cmd_stall | hfd_pkg::cmd_t
//   rsp     | out       | rsp_valid, rsp_stall | hfd_pkg::rsp_t
//
// one item per cycle sustained unless the output stalls; the result passes through stage 1
// (state update and store access), then the output register.
// the latest payload byte sits in a holding register and goes to memory
// when the next one arrives, so each byte costs one store write.
// reset clears all control state; store contents are masked by a fill count.
// a stalled output holds; the input stalls only when both stages are full.
module host_frame_deframer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  hfd_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output hfd_pkg::rsp_t  rsp
);

	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_SYNC = 4'b0010,
		PH_LEN  = 4'b0100,
		PH_BODY = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		SEL_ZERO = 3'b001,
		SEL_PEND = 3'b010,
		SEL_MEM  = 3'b100
	} rsel_t;

	// frame state
	phase_t     phase_q;
	logic [7:0] stored_count_q;
	logic [7:0] expected_len_q;
	logic [7:0] running_sum_q;
	logic [7:0] filled_count_q;
	logic       xor_mode_q;
	logic [7:0] pending_q;

	// pipeline
	logic       valid_s1;
	logic [1:0] ev_s1;
	logic [7:0] flen_s1;
	rsel_t      rsel_s1;
	logic [7:0] pend_s1;
	logic       out_valid_q;
	hfd_pkg::rsp_t out_q;

	logic       s1_move;
	logic       cmd_fire;
	logic       rx_fire;
	logic       is_payload;
	logic [1:0] ev_d;
	logic [7:0] flen_d;
	rsel_t      rsel_d;
	logic [7:0] mem_rd_q;
	logic [7:0] s1_data;
	hfd_pkg::store_wr_t wr;
	hfd_pkg::store_rd_t rd;

	// handshake
	assign s1_move   = !out_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !s1_move;
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign rx_fire   = cmd_fire && (cmd.req_type == hfd_pkg::REQ_RX);

	// payload byte while the frame still expects one
	assign is_payload = (expected_len_q != 8'd0) &&
		(stored_count_q < (expected_len_q - 8'd1));

	// event for the current item
	always_comb begin
		ev_d   = hfd_pkg::EV_CONSUMED;
		flen_d = 8'd0;
		if (cmd.req_type == hfd_pkg::REQ_READ) begin
			ev_d = hfd_pkg::EV_READ;
		end else if (phase_q == PH_BODY && !is_payload) begin
			if (cmd.rx_byte == running_sum_q) begin
				ev_d   = hfd_pkg::EV_ACCEPTED;
				flen_d = stored_count_q;
			end else begin
				ev_d = hfd_pkg::EV_MISMATCH;
			end
		end
	end

	// read source: zero past the fill, holding register for the newest byte
	always_comb begin
		if (cmd.req_type != hfd_pkg::REQ_READ || cmd.read_index >= filled_count_q) begin
			rsel_d = SEL_ZERO;
		end else if (cmd.read_index == filled_count_q - 8'd1) begin
			rsel_d = SEL_PEND;
		end else begin
			rsel_d = SEL_MEM;
		end
	end

	// store ports: previous byte retires to memory, xored with the new one in xor mode
	always_comb begin
		wr.en   = rx_fire && (phase_q == PH_BODY) && is_payload &&
			(stored_count_q != 8'd0);
		wr.addr = hfd_pkg::STORE_AW'(stored_count_q - 8'd1);
		wr.data = (xor_mode_q && stored_count_q > 8'd2) ?
			(pending_q ^ cmd.rx_byte) : pending_q;
		rd.en   = cmd_fire && (cmd.req_type == hfd_pkg::REQ_READ);
		rd.addr = hfd_pkg::STORE_AW'(cmd.read_index);
	end

	hfd_store u_store (
		.clk       (clk),
		.wr        (wr),
		.rd        (rd),
		.rd_data_q (mem_rd_q)
	);

	// frame state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			stored_count_q <= 8'd0;
			expected_len_q <= 8'd0;
			running_sum_q  <= 8'd0;
			filled_count_q <= 8'd0;
			xor_mode_q     <= 1'b0;
		end else if (rx_fire) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (cmd.rx_byte == hfd_pkg::SYNC_BYTE) begin
						phase_q <= PH_SYNC;
					end
				end
				PH_SYNC: begin
					if (cmd.rx_byte == hfd_pkg::HDR_BYTE) begin
						phase_q        <= PH_LEN;
						filled_count_q <= 8'd0;
						xor_mode_q     <= 1'b0;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_LEN: begin
					if (cmd.rx_byte != hfd_pkg::SYNC_BYTE) begin
						expected_len_q <= cmd.rx_byte;
						running_sum_q  <= cmd.rx_byte;
						stored_count_q <= 8'd0;
						phase_q        <= PH_BODY;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_BODY: begin
					if (is_payload) begin
						if (stored_count_q == 8'd1) begin
							xor_mode_q <= (cmd.rx_byte == hfd_pkg::XOR_MARK);
						end
						running_sum_q  <= running_sum_q + cmd.rx_byte;
						stored_count_q <= stored_count_q + 8'd1;
						filled_count_q <= stored_count_q + 8'd1;
					end else begin
						phase_q        <= PH_HUNT;
						stored_count_q <= 8'd0;
						running_sum_q  <= 8'd0;
						expected_len_q <= 8'd0;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// newest payload byte, not yet in memory
	always_ff @(posedge clk) begin
		if (rx_fire && phase_q == PH_BODY && is_payload) begin
			pending_q <= cmd.rx_byte;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			ev_s1   <= ev_d;
			flen_s1 <= flen_d;
			rsel_s1 <= rsel_d;
			pend_s1 <= pending_q;
		end
	end

	// read data select
	always_comb begin
		unique case (rsel_s1)
			SEL_PEND: s1_data = pend_s1;
			SEL_MEM:  s1_data = mem_rd_q;
			default:  s1_data = 8'd0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			out_q.event_res    <= ev_s1;
			out_q.frame_length <= flen_s1;
			out_q.read_data    <= s1_data;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	// while taking payload, fill count tracks the byte count
	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> filled_count_q == stored_count_q)
		else $error("fill count out of step with stored count");

	// a frame never holds more than 253 payload bytes
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		stored_count_q <= 8'd253 && filled_count_q <= 8'd253)
		else $error("payload count beyond frame limit");

	// only read replies carry data
	a_data_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.event_res != hfd_pkg::EV_READ |-> rsp.read_data == 8'd0)
		else $error("read data on a non-read event");

	// input stalls only with stage 1 full and blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && out_valid_q && rsp_stall)
		else $error("input stalled without a full pipeline");
`endif

endmodule
